FILE: rtl/core/multi_channel_shutter_pulse_timer_core_macros.svh
// assertion macros for the shutter pulse timer core
`ifndef MULTI_CHANNEL_SHUTTER_PULSE_TIMER_CORE_MACROS_SVH
`define MULTI_CHANNEL_SHUTTER_PULSE_TIMER_CORE_MACROS_SVH

// checked on every edge outside reset
`define MCSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MCSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/mcsp_pkg.sv
// shared types and constants of the shutter pulse timer core
package mcsp_pkg;

  localparam int CHANNELS_DEF = 24;
  localparam int CHANNELS_MAX = 64;
  localparam int LINES_W      = 24;
  localparam int ACT_W        = 2;
  localparam int CH_W         = 5;
  localparam int DLY_W        = 16;
  localparam int PW_W         = 16;
  localparam int EL_W         = 18;

  localparam logic [EL_W-1:0] ELAPSED_MAX = {EL_W{1'b1}};
  localparam logic [PW_W-1:0] PW_RESET    = 16'd1000;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

  typedef struct packed {
    logic apply;
    logic eval;
    logic load;
  } dp_cmd_t;

endpackage

FILE: rtl/core/mcsp_if.sv
// handshake channels of the shutter pulse timer core
interface mcsp_in_if;
  logic                           valid;
  logic                           ready;
  logic [mcsp_pkg::ACT_W-1:0]     action;
  logic [mcsp_pkg::CH_W-1:0]      channel;
  logic [mcsp_pkg::DLY_W-1:0]     delay;
  logic                           enable;

  modport source (output valid, action, channel, delay, enable, input ready);
  modport sink   (input valid, action, channel, delay, enable, output ready);
endinterface

interface mcsp_out_if;
  logic                           valid;
  logic                           ready;
  logic [mcsp_pkg::LINES_W-1:0]   shutter_lines;
  logic                           running;

  modport source (output valid, shutter_lines, running, input ready);
  modport sink   (input valid, shutter_lines, running, output ready);
endinterface

interface mcsp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mcsp_pkg::PW_W-1:0]      pulse_width;

  modport source (output valid, pulse_width, input ready);
  modport sink   (input valid, pulse_width, output ready);
endinterface

FILE: rtl/core/multi_channel_shutter_pulse_timer_core.sv
// top level of the multi-channel shutter pulse timer core
//
//   port    dir  payload
//   in_ch   in   action, channel, delay, enable
//   out_ch  out  shutter_lines, running
//   cfg_ch  in   pulse_width
//
// an item passes through accept and state update, per-channel compare,
// then end check and result load; the next item is accepted after that
// all channels are compared in parallel in the compare cycle
// rst_n clears the enable table, elapsed counter and sequence flag; pulse width 1000
// a stalled result holds the block in the load cycle; cfg writes are always taken
module multi_channel_shutter_pulse_timer_core #(
  parameter int CHANNELS = mcsp_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mcsp_in_if.sink           in_ch,
  mcsp_out_if.source        out_ch,
  mcsp_cfg_if.sink          cfg_ch
);

  mcsp_pkg::dp_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  mcsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  mcsp_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .action          (in_ch.action),
    .channel         (in_ch.channel),
    .delay           (in_ch.delay),
    .enable          (in_ch.enable),
    .cfg_we          (cfg_ch.valid),
    .cfg_pulse_width (cfg_ch.pulse_width),
    .shutter_lines   (out_ch.shutter_lines),
    .running         (out_ch.running)
  );

endmodule

FILE: rtl/core/mcsp_ctrl.sv
// controller state machine of the shutter pulse timer core
`include "multi_channel_shutter_pulse_timer_core_macros.svh"

module mcsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mcsp_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       load;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign load      = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  assign cmd.apply = accept;
  assign cmd.eval  = (state_r == ST_EVAL);
  assign cmd.load  = load;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_FIN;
      ST_FIN:  if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MCSP_ASSERT(a_accept_to_eval, (in_valid && in_ready) |=> (state_r == ST_EVAL), "item not evaluated")
  `MCSP_ASSERT(a_eval_to_fin, (state_r == ST_EVAL) |=> (state_r == ST_FIN), "eval not followed by finish")
  `MCSP_ASSERT(a_fin_stall, (state_r == ST_FIN && out_valid_r && !out_ready) |=> (state_r == ST_FIN), "result overwritten")
  `MCSP_ASSERT(a_fin_load, (state_r == ST_FIN && !(out_valid_r && !out_ready)) |=> (out_valid_r && state_r == ST_IDLE), "result not presented")

endmodule

FILE: rtl/core/mcsp_dp.sv
// channel table, elapsed counter and line compare of the shutter pulse timer core
module mcsp_dp #(
  parameter int CHANNELS = mcsp_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mcsp_pkg::dp_cmd_t              cmd,
  input  logic [mcsp_pkg::ACT_W-1:0]     action,
  input  logic [mcsp_pkg::CH_W-1:0]      channel,
  input  logic [mcsp_pkg::DLY_W-1:0]     delay,
  input  logic                           enable,
  input  logic                           cfg_we,
  input  logic [mcsp_pkg::PW_W-1:0]      cfg_pulse_width,
  output logic [mcsp_pkg::LINES_W-1:0]   shutter_lines,
  output logic                           running
);

  localparam int SUM_W = mcsp_pkg::DLY_W + 1;

  logic [mcsp_pkg::DLY_W-1:0]   dly_r [CHANNELS];
  logic [CHANNELS-1:0]          en_r;
  logic [mcsp_pkg::EL_W-1:0]    elapsed_r;
  logic                         active_r, active_nxt;
  logic [mcsp_pkg::PW_W-1:0]    pw_r;
  logic [CHANNELS-1:0]          win_r, win_nxt;
  logic [CHANNELS-1:0]          done_r, done_nxt;
  logic [mcsp_pkg::LINES_W-1:0] lines_r;
  logic                         running_r;
  logic [mcsp_pkg::CHANNELS_MAX-1:0] win_ext;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      logic [SUM_W-1:0] stop;
      logic             past_start;
      logic             past_stop;
      stop       = SUM_W'(dly_r[i]) + SUM_W'(pw_r);
      past_start = elapsed_r >= mcsp_pkg::EL_W'(dly_r[i]);
      past_stop  = elapsed_r >= mcsp_pkg::EL_W'(stop);
      win_nxt[i]  = en_r[i] && past_start && !past_stop;
      done_nxt[i] = !en_r[i] || past_stop;
    end
  end

  assign active_nxt = active_r && !(&done_r);
  assign win_ext    = mcsp_pkg::CHANNELS_MAX'(win_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= '0;
      elapsed_r <= '0;
      active_r  <= 1'b0;
      pw_r      <= mcsp_pkg::PW_RESET;
    end else begin
      if (cfg_we) pw_r <= cfg_pulse_width;
      if (cmd.apply) begin
        unique case (action)
          mcsp_pkg::ACT_WRITE: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (32'(channel) == i) en_r[i] <= enable;
            end
          end
          mcsp_pkg::ACT_START: begin
            elapsed_r <= '0;
            active_r  <= 1'b1;
          end
          mcsp_pkg::ACT_TICK: begin
            if (active_r && elapsed_r != mcsp_pkg::ELAPSED_MAX) elapsed_r <= elapsed_r + 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.load) active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && action == mcsp_pkg::ACT_WRITE) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (32'(channel) == i) dly_r[i] <= delay;
      end
    end
    if (cmd.eval) begin
      win_r  <= win_nxt;
      done_r <= done_nxt;
    end
    if (cmd.load) begin
      lines_r   <= active_nxt ? ~win_ext[mcsp_pkg::LINES_W-1:0] : '1;
      running_r <= active_nxt;
    end
  end

  assign shutter_lines = lines_r;
  assign running       = running_r;

endmodule

FILE: sim/testbench.sv
// testbench for the multi-channel shutter pulse timer core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LATENCY     = 3;
  localparam int LONG_HOLD   = 200;
  localparam int PHASE_ITEMS = 200;
  localparam int LONG_TICKS  = 20;
  localparam logic [mcsp_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [mcsp_pkg::LINES_W-1:0] lines;
    logic                         running;
  } shutter_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mcsp_in_if  in_ch();
  mcsp_out_if out_ch();
  mcsp_cfg_if cfg_ch();

  multi_channel_shutter_pulse_timer_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // timer state as the testbench sees it
  logic [mcsp_pkg::DLY_W-1:0] tbl_delay  [mcsp_pkg::CHANNELS_DEF];
  logic                       tbl_enable [mcsp_pkg::CHANNELS_DEF];
  logic [mcsp_pkg::EL_W-1:0]  elapsed_units;
  logic                       seq_active;
  logic [mcsp_pkg::PW_W-1:0]  pulse_width;

  shutter_result_t  expected_results[$];

  int unsigned cycle_count;
  int          error_count;
  int          items_sent;
  int          results_checked;
  int          sink_hold;
  logic        no_gaps;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 50) begin
      $display("%0t mismatch in %s: got %h, want %h (result %0d)", $realtime, what, got,
               want, results_checked);
    end
    error_count++;
  endtask

  task automatic predict_step(input logic [mcsp_pkg::ACT_W-1:0] act,
                              input logic [mcsp_pkg::CH_W-1:0] ch,
                              input logic [mcsp_pkg::DLY_W-1:0] dly, input logic en);
    shutter_result_t res;
    logic [mcsp_pkg::EL_W-1:0] seq_end;
    logic [mcsp_pkg::EL_W-1:0] d_ext;
    logic [mcsp_pkg::EL_W-1:0] w_ext;
    case (act)
      mcsp_pkg::ACT_WRITE: begin
        if (ch < mcsp_pkg::CHANNELS_DEF) begin
          tbl_delay[ch]  = dly;
          tbl_enable[ch] = en;
        end
      end
      mcsp_pkg::ACT_START: begin
        elapsed_units = '0;
        seq_active    = 1'b1;
      end
      mcsp_pkg::ACT_TICK: begin
        if (seq_active && elapsed_units != mcsp_pkg::ELAPSED_MAX) elapsed_units++;
      end
      default: ;
    endcase
    seq_end = '0;
    w_ext   = mcsp_pkg::EL_W'(pulse_width);
    for (int i = 0; i < mcsp_pkg::CHANNELS_DEF; i++) begin
      d_ext = mcsp_pkg::EL_W'(tbl_delay[i]);
      if (tbl_enable[i] && d_ext + w_ext > seq_end) seq_end = d_ext + w_ext;
    end
    if (seq_active && elapsed_units >= seq_end) seq_active = 1'b0;
    res.lines = '1;
    if (seq_active) begin
      for (int i = 0; i < mcsp_pkg::CHANNELS_DEF; i++) begin
        d_ext = mcsp_pkg::EL_W'(tbl_delay[i]);
        if (tbl_enable[i] && elapsed_units >= d_ext && elapsed_units < d_ext + w_ext)
          res.lines[i] = 1'b0;
      end
    end
    res.running = seq_active;
    expected_results.push_back(res);
  endtask

  task automatic send_item(input logic [mcsp_pkg::ACT_W-1:0] act,
                           input logic [mcsp_pkg::CH_W-1:0] ch,
                           input logic [mcsp_pkg::DLY_W-1:0] dly, input logic en);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.channel <= ch;
    in_ch.delay   <= dly;
    in_ch.enable  <= en;
    do @(posedge clk); while (!in_ch.ready);
    predict_step(act, ch, dly, en);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic write_pulse_width(input logic [mcsp_pkg::PW_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.pulse_width <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    pulse_width = value;
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  task automatic clear_table();
    for (int ch = 0; ch < mcsp_pkg::CHANNELS_DEF; ch++)
      send_item(mcsp_pkg::ACT_WRITE, mcsp_pkg::CH_W'(ch), '0, 1'b0);
  endtask

  task automatic send_random_item();
    int                         pick;
    logic [mcsp_pkg::ACT_W-1:0] act;
    logic [mcsp_pkg::CH_W-1:0]  ch;
    logic [mcsp_pkg::DLY_W-1:0] dly;
    logic                       en;
    pick = $urandom_range(0, 99);
    if (pick < 18) act = mcsp_pkg::ACT_WRITE;
    else if (pick < 24) act = mcsp_pkg::ACT_START;
    else if (pick < 97) act = mcsp_pkg::ACT_TICK;
    else act = ACT_UNUSED;
    ch  = ($urandom_range(0, 9) == 0) ? mcsp_pkg::CH_W'($urandom_range(24, 31))
                                      : mcsp_pkg::CH_W'($urandom_range(0, 23));
    dly = ($urandom_range(0, 19) == 0) ? mcsp_pkg::DLY_W'($urandom_range(0, 65535))
                                       : mcsp_pkg::DLY_W'($urandom_range(0, 24));
    en  = ($urandom_range(0, 1) == 1);
    send_item(act, ch, dly, en);
  endtask

  // result receiver with random stalls and an occasional long hold-off
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        @(negedge clk) out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin : result_check
    shutter_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending", 32'(out_ch.shutter_lines), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.shutter_lines !== want.lines)
          report_mismatch("shutter_lines", 32'(out_ch.shutter_lines), 32'(want.lines));
        if (out_ch.running !== want.running)
          report_mismatch("running", 32'(out_ch.running), 32'(want.running));
      end
      results_checked++;
    end
  end

  // empty table, idle ticks, unused action, out-of-range channels, default width
  task automatic test_reset_defaults();
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
    send_item(ACT_UNUSED, 5'd31, 16'hFFFF, 1'b1);
    send_item(mcsp_pkg::ACT_WRITE, 5'd31, 16'd0, 1'b1);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_WRITE, 5'd24, 16'd0, 1'b1);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_WRITE, 5'd5, 16'd0, 1'b1);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
    send_item(ACT_UNUSED, 5'd0, 16'd0, 1'b0);
  endtask

  // short pulses on channels 9 and 23, disabled max delay on channel 0, restart
  task automatic test_directed();
    write_pulse_width(16'd3);
    send_item(mcsp_pkg::ACT_WRITE, 5'd5, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_WRITE, 5'd0, 16'hFFFF, 1'b0);
    send_item(mcsp_pkg::ACT_WRITE, 5'd23, 16'd2, 1'b1);
    send_item(mcsp_pkg::ACT_WRITE, 5'd9, 16'd0, 1'b1);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    repeat (6) send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
  endtask

  // zero width never pulls a line low; max width, then writes end the sequence
  task automatic test_pulse_width_extremes();
    write_pulse_width(16'd0);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    repeat (3) send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
    write_pulse_width(16'hFFFF);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    repeat (2) send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_WRITE, 5'd9, 16'd0, 1'b0);
    send_item(mcsp_pkg::ACT_WRITE, 5'd23, 16'd2, 1'b0);
    send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
  endtask

  // delay near the top of its range, pulse end carries past 16 bits
  task automatic test_long_delay();
    write_pulse_width(16'd8);
    clear_table();
    send_item(mcsp_pkg::ACT_WRITE, 5'd17, 16'd65530, 1'b1);
    send_item(mcsp_pkg::ACT_WRITE, 5'd2, 16'd65529, 1'b0);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    no_gaps = 1'b1;
    repeat (LONG_TICKS) send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
    no_gaps = 1'b0;
    write_pulse_width(16'hFFFF);
    send_item(mcsp_pkg::ACT_WRITE, 5'd4, 16'hFFFF, 1'b1);
    send_item(mcsp_pkg::ACT_START, 5'd0, 16'd0, 1'b0);
    repeat (LONG_TICKS) send_item(mcsp_pkg::ACT_TICK, 5'd0, 16'd0, 1'b0);
  endtask

  task automatic test_random();
    logic [mcsp_pkg::PW_W-1:0] widths[5] = '{16'd1, 16'd4, 16'd0, 16'd12, 16'hFFFF};
    foreach (widths[p]) begin
      write_pulse_width(widths[p]);
      clear_table();
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (j % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_random_item();
      end
      no_gaps = 1'b0;
    end
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_backpressure();
    write_pulse_width(16'd5);
    sink_hold = LONG_HOLD;
    for (int j = 0; j < 40; j++) send_random_item();
  endtask

  initial begin : run
    rst_n              = 1'b0;
    no_gaps            = 1'b0;
    sink_hold          = 0;
    in_ch.valid        = 1'b0;
    in_ch.action       = mcsp_pkg::ACT_WRITE;
    in_ch.channel      = '0;
    in_ch.delay        = '0;
    in_ch.enable       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.pulse_width = mcsp_pkg::PW_RESET;
    for (int i = 0; i < mcsp_pkg::CHANNELS_DEF; i++) begin
      tbl_delay[i]  = '0;
      tbl_enable[i] = 1'b0;
    end
    elapsed_units = '0;
    seq_active    = 1'b0;
    pulse_width   = mcsp_pkg::PW_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_reset_defaults();
    test_directed();
    test_pulse_width_extremes();
    test_long_delay();
    test_random();
    test_backpressure();
    wait_drained();
    repeat (10) @(posedge clk);

    $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
             results_checked, error_count);
    $display("widths 0 to 65535, out-of-range writes, long delay carry, stalls and hold-off");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
